@@ sv/sfp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the spatial footprint prefetcher.
// No dependencies.
package sfp_pkg;

   localparam int ADDR_W      = 48;
   localparam int PC_W        = 12;
   localparam int KEY_W       = 32;
   localparam int KEY_SEC_W   = 20;
   localparam int MAX_RESULTS = 32;
   localparam int RBC_W       = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 2;

   localparam logic [RBC_W-1:0]      RBC_RESET = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_RBC   = 2'd0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACT,
      ST_DEF,
      ST_SCAN,
      ST_FP
   } state_type;

   typedef enum logic {
      SCAN_LOOKUP,
      SCAN_STORE
   } scan_mode_type;

endpackage

@@ sv/spatial_footprint_prefetcher.sv @@
`timescale 1ns / 1ps
// Spatial footprint prefetcher: active-sector table and history table in
// synchronous memories, one sequencer. Depends on sfp_pkg.
//
// Usage
//   Input: drive req_* and raise start while busy is low; the beat is taken
//   at that edge. busy stays high until every prefetch of the access is out.
//   Results: each prefetch appears for one cycle with rsp_valid high;
//   rsp_last_of_run marks the final one. The receiver cannot stall.
//   Config: APB port, recovery_block_count at byte address 0, pready tied high.
// Flow (accept to next accept)
//   A hit returns straight to idle. A miss in an open sector runs the
//   default run (none if the sector came from a footprint), plus a
//   history store when the missed block was already touched. A history
//   lookup or store scans the history memory one entry per cycle.
//   Footprint prefetches issue one per cycle.
//   The single read port of each memory sets this pacing.
// Reset
//   After reset a clearing pass over every entry of both tables runs with
//   busy high; configuration writes are taken meanwhile.
// Sector and table sizes must be powers of two.
module spatial_footprint_prefetcher #(
   parameter int BLOCKS_PER_SECTOR = 32,
   parameter int BLOCK_OFFSET_BITS = 6,
   parameter int HISTORY_ENTRIES   = 64,
   parameter int ACTIVE_ENTRIES    = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [sfp_pkg::ADDR_W-1:0]             req_access_address,
   input  logic [sfp_pkg::PC_W-1:0]               req_pc_low,
   input  logic                                   req_is_hit,
   output logic                                   rsp_valid,
   output logic [sfp_pkg::ADDR_W-1:0]             rsp_prefetch_address,
   output logic                                   rsp_from_footprint,
   output logic                                   rsp_last_of_run,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [sfp_pkg::CSR_ADDR_W-1:0]         paddr,
   input  logic [sfp_pkg::CSR_DATA_W-1:0]         pwdata,
   output logic [sfp_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                   pready
);

   localparam int OFF = BLOCK_OFFSET_BITS;
   localparam int SB  = $clog2(BLOCKS_PER_SECTOR);
   localparam int FW  = BLOCKS_PER_SECTOR;
   localparam int BW  = sfp_pkg::ADDR_W - OFF;
   localparam int TW  = sfp_pkg::ADDR_W - OFF - SB;
   localparam int AW  = $clog2(ACTIVE_ENTRIES);
   localparam int HW  = $clog2(HISTORY_ENTRIES);
   localparam int MAXE = (ACTIVE_ENTRIES > HISTORY_ENTRIES) ? ACTIVE_ENTRIES : HISTORY_ENTRIES;
   localparam int CW  = $clog2(MAXE) + 1;
   localparam int EW  = $clog2(sfp_pkg::MAX_RESULTS);

   typedef struct packed {
      logic                          valid;
      logic [TW-1:0]                 tag;
      logic [FW-1:0]                 fp;
      logic [sfp_pkg::KEY_W-1:0]     key;
      logic                          used;
   } act_word_type;

   typedef struct packed {
      logic                          occ;
      logic                          vld;
      logic [sfp_pkg::KEY_W-1:0]     key;
      logic [FW-1:0]                 fp;
   } hist_word_type;

   act_word_type  act_mem [ACTIVE_ENTRIES];
   hist_word_type hist_mem [HISTORY_ENTRIES];

   act_word_type  act_rd_ff;
   hist_word_type hist_rd_ff;

   sfp_pkg::state_type     state_ff, state_in;
   sfp_pkg::scan_mode_type mode_ff, mode_in;

   logic [sfp_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [sfp_pkg::PC_W-1:0]   pc_ff, pc_in;
   logic                       hit_ff, hit_in;
   logic [sfp_pkg::RBC_W-1:0]  rbc_ff, rbc_in;
   logic [CW-1:0]              clr_ff, clr_in;
   logic [HW:0]                scan_ff, scan_in;
   logic                       chk_vld_ff, chk_vld_in;
   logic [HW-1:0]              chk_idx_ff, chk_idx_in;
   logic [HW-1:0]              fifo_ff, fifo_in;
   logic [sfp_pkg::KEY_W-1:0]  st_key_ff, st_key_in;
   logic [FW-1:0]              st_fp_ff, st_fp_in;
   logic                       close_ff, close_in;
   logic [FW-1:0]              rem_ff, rem_in;
   logic [EW-1:0]              ecnt_ff, ecnt_in;
   logic [BW-1:0]              blk_ff, blk_in;
   logic [sfp_pkg::RBC_W-1:0]  k_ff, k_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [sfp_pkg::ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic                       rsp_fp_ff, rsp_fp_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic          act_we;
   logic [AW-1:0] act_wa, act_ra;
   act_word_type  act_wd;
   logic          hist_we;
   logic [HW-1:0] hist_wa, hist_ra;
   hist_word_type hist_wd;

   logic [TW-1:0]             sector;
   logic [SB-1:0]             line;
   logic [FW-1:0]             bit_mask;
   logic [AW-1:0]             slot;
   logic [sfp_pkg::KEY_W-1:0] key;
   logic                      is_open, touched, match;
   logic [FW-1:0]             iso;
   logic [SB-1:0]             iso_idx;
   logic                      fp_last, def_last;

   // apb
   assign pready = 1'b1;
   assign prdata = {{(sfp_pkg::CSR_DATA_W - sfp_pkg::RBC_W){1'b0}}, rbc_ff};
   always_comb begin
      rbc_in = rbc_ff;
      if (psel && penable && pwrite && (paddr[sfp_pkg::CSR_ADDR_W-1:0] == sfp_pkg::REG_RBC))
         rbc_in = pwdata[sfp_pkg::RBC_W-1:0];
   end

   assign sector   = addr_ff[sfp_pkg::ADDR_W-1:OFF+SB];
   assign line     = addr_ff[OFF+SB-1:OFF];
   assign bit_mask = FW'(1) << line;
   assign slot     = sector[AW-1:0];
   assign key      = {sector[sfp_pkg::KEY_SEC_W-1:0], pc_ff};
   assign is_open  = act_rd_ff.valid && (act_rd_ff.tag == sector);
   assign touched  = (act_rd_ff.fp & bit_mask) != '0;
   assign match    = chk_vld_ff && hist_rd_ff.occ && (hist_rd_ff.key ==
                     ((mode_ff == sfp_pkg::SCAN_LOOKUP) ? key : st_key_ff)) &&
                     ((mode_ff == sfp_pkg::SCAN_STORE) || hist_rd_ff.vld);

   // lowest remaining footprint block
   assign iso = rem_ff & (~rem_ff + FW'(1));
   always_comb begin
      iso_idx = '0;
      for (int i = 0; i < FW; i++)
         if (iso[i]) iso_idx = iso_idx | SB'(i);
   end
   assign fp_last  = ((rem_ff & ~iso) == '0) || (ecnt_ff == EW'(sfp_pkg::MAX_RESULTS - 1));
   assign def_last = (k_ff == rbc_ff);

   assign act_ra  = req_access_address[OFF+SB+AW-1:OFF+SB];
   assign hist_ra = scan_ff[HW-1:0];

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      addr_in      = addr_ff;
      pc_in        = pc_ff;
      hit_in       = hit_ff;
      clr_in       = clr_ff;
      scan_in      = scan_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      fifo_in      = fifo_ff;
      st_key_in    = st_key_ff;
      st_fp_in     = st_fp_ff;
      close_in     = close_ff;
      rem_in       = rem_ff;
      ecnt_in      = ecnt_ff;
      blk_in       = blk_ff;
      k_in         = k_ff;
      rsp_valid_in = 1'b0;
      rsp_addr_in  = rsp_addr_ff;
      rsp_fp_in    = rsp_fp_ff;
      rsp_last_in  = rsp_last_ff;
      act_we       = 1'b0;
      act_wa       = slot;
      act_wd       = act_rd_ff;
      hist_we      = 1'b0;
      hist_wa      = chk_idx_ff;
      hist_wd      = hist_rd_ff;

      case (state_ff)
         sfp_pkg::ST_CLEAR: begin
            act_wd  = '0;
            hist_wd = '0;
            act_wa  = clr_ff[AW-1:0];
            hist_wa = clr_ff[HW-1:0];
            act_we  = clr_ff < CW'(ACTIVE_ENTRIES);
            hist_we = clr_ff < CW'(HISTORY_ENTRIES);
            clr_in  = clr_ff + CW'(1);
            if (clr_ff == CW'(MAXE - 1)) state_in = sfp_pkg::ST_IDLE;
         end
         sfp_pkg::ST_IDLE: begin
            if (start) begin
               addr_in  = req_access_address;
               pc_in    = req_pc_low;
               hit_in   = req_is_hit;
               state_in = sfp_pkg::ST_ACT;
            end
         end
         sfp_pkg::ST_ACT: begin
            k_in    = sfp_pkg::RBC_W'(1);
            blk_in  = addr_ff[sfp_pkg::ADDR_W-1:OFF] + BW'(1);
            scan_in = '0;
            if (hit_ff) begin
               act_we    = is_open;
               act_wd.fp = act_rd_ff.fp | bit_mask;
               state_in  = sfp_pkg::ST_IDLE;
            end else if (is_open) begin
               act_we    = 1'b1;
               st_key_in = act_rd_ff.key;
               st_fp_in  = act_rd_ff.fp;
               close_in  = touched;
               mode_in   = sfp_pkg::SCAN_STORE;
               if (touched) act_wd = '{1'b1, sector, bit_mask, key, 1'b0};
               else act_wd.fp = act_rd_ff.fp | bit_mask;
               if (!act_rd_ff.used) state_in = sfp_pkg::ST_DEF;
               else if (touched) state_in = sfp_pkg::ST_SCAN;
               else state_in = sfp_pkg::ST_IDLE;
            end else begin
               mode_in  = sfp_pkg::SCAN_LOOKUP;
               state_in = sfp_pkg::ST_SCAN;
            end
         end
         sfp_pkg::ST_DEF: begin
            if (rbc_ff == '0 || def_last) begin
               scan_in  = '0;
               state_in = close_ff ? sfp_pkg::ST_SCAN : sfp_pkg::ST_IDLE;
            end
            if (rbc_ff != '0) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = {blk_ff, {OFF{1'b0}}};
               rsp_fp_in    = 1'b0;
               rsp_last_in  = def_last;
               k_in         = k_ff + sfp_pkg::RBC_W'(1);
               blk_in       = blk_ff + BW'(1);
            end
         end
         sfp_pkg::ST_SCAN: begin
            if (match || (chk_vld_ff && chk_idx_ff == HW'(HISTORY_ENTRIES - 1))) begin
               if (mode_ff == sfp_pkg::SCAN_LOOKUP) begin
                  act_we = 1'b1;
                  act_wd = '{1'b1, sector, bit_mask, key, match};
                  if (match) begin
                     hist_we     = 1'b1;
                     hist_wd.vld = 1'b0;
                     rem_in      = hist_rd_ff.fp;
                     ecnt_in     = '0;
                     state_in    = sfp_pkg::ST_FP;
                  end else begin
                     close_in = 1'b0;
                     state_in = sfp_pkg::ST_DEF;
                  end
               end else begin
                  hist_we = 1'b1;
                  hist_wd = '{1'b1, 1'b1, st_key_ff, st_fp_ff};
                  if (!match) begin
                     hist_wa = fifo_ff;
                     fifo_in = (fifo_ff == HW'(HISTORY_ENTRIES - 1)) ? '0 : fifo_ff + HW'(1);
                  end
                  state_in = sfp_pkg::ST_IDLE;
               end
            end else if (scan_ff < (HW+1)'(HISTORY_ENTRIES)) begin
               chk_vld_in = 1'b1;
               chk_idx_in = scan_ff[HW-1:0];
               scan_in    = scan_ff + (HW+1)'(1);
            end
         end
         sfp_pkg::ST_FP: begin
            if (rem_ff == '0) begin
               state_in = sfp_pkg::ST_IDLE;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = {sector, iso_idx, {OFF{1'b0}}};
               rsp_fp_in    = 1'b1;
               rsp_last_in  = fp_last;
               rem_in       = rem_ff & ~iso;
               ecnt_in      = ecnt_ff + EW'(1);
               if (fp_last) state_in = sfp_pkg::ST_IDLE;
            end
         end
         default: state_in = sfp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfp_pkg::ST_CLEAR;
         mode_ff      <= sfp_pkg::SCAN_LOOKUP;
         rbc_ff       <= sfp_pkg::RBC_RESET;
         clr_ff       <= '0;
         scan_ff      <= '0;
         chk_vld_ff   <= 1'b0;
         fifo_ff      <= '0;
         close_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rbc_ff       <= rbc_in;
         clr_ff       <= clr_in;
         scan_ff      <= scan_in;
         chk_vld_ff   <= chk_vld_in;
         fifo_ff      <= fifo_in;
         close_ff     <= close_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      pc_ff       <= pc_in;
      hit_ff      <= hit_in;
      chk_idx_ff  <= chk_idx_in;
      st_key_ff   <= st_key_in;
      st_fp_ff    <= st_fp_in;
      rem_ff      <= rem_in;
      ecnt_ff     <= ecnt_in;
      blk_ff      <= blk_in;
      k_ff        <= k_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_fp_ff   <= rsp_fp_in;
      rsp_last_ff <= rsp_last_in;
   end

   // active-sector table
   always_ff @(posedge clock) begin
      if (act_we) act_mem[act_wa] <= act_wd;
      act_rd_ff <= act_mem[act_ra];
   end

   // history table
   always_ff @(posedge clock) begin
      if (hist_we) hist_mem[hist_wa] <= hist_wd;
      hist_rd_ff <= hist_mem[hist_ra];
   end

   assign busy                 = state_ff != sfp_pkg::ST_IDLE;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_prefetch_address = rsp_addr_ff;
   assign rsp_from_footprint   = rsp_fp_ff;
   assign rsp_last_of_run      = rsp_last_ff;

endmodule

@@ verif/spatial_footprint_prefetcher_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for spatial_footprint_prefetcher: directed table, full footprint,
// then random sector walks, each access predicted in-bench and checked beat by beat.
// Depends on sfp_pkg and the block itself.
module spatial_footprint_prefetcher_tb;

   localparam int LIMIT = 2000000;

   typedef struct packed {
      logic [sfp_pkg::ADDR_W-1:0] addr;
      logic                       from_fp;
      logic                       last;
   } prefetch_type;

   typedef struct {
      logic [sfp_pkg::ADDR_W-1:0] addr;
      logic [sfp_pkg::PC_W-1:0]   pc;
      logic                       hit;
      int                         rbc;       // recovery count to hold for this row
      int                         exp_n;     // -1 where the row is left to the predictor
      logic [sfp_pkg::ADDR_W-1:0] exp_first;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [sfp_pkg::ADDR_W-1:0] req_access_address = '0;
   logic [sfp_pkg::PC_W-1:0]   req_pc_low = '0;
   logic                       req_is_hit = 0;
   logic                       rsp_valid;
   logic [sfp_pkg::ADDR_W-1:0] rsp_prefetch_address;
   logic                       rsp_from_footprint;
   logic                       rsp_last_of_run;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [sfp_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [sfp_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [sfp_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   spatial_footprint_prefetcher uut (.*);

   always #5 clock = ~clock;

   int errors = 0;
   int cycles = 0;
   int gap_pct = 0;
   prefetch_type prefetch_q[$];

   // predictor state
   logic [sfp_pkg::RBC_W-1:0] rbc;
   logic                      act_valid[64];
   logic [36:0]               act_tag[64];
   logic [31:0]               act_fp[64];
   logic [sfp_pkg::KEY_W-1:0] act_key[64];
   logic                      act_used[64];
   logic                      hist_occ[64];
   logic                      hist_valid[64];
   logic [sfp_pkg::KEY_W-1:0] hist_key[64];
   logic [31:0]               hist_fp[64];
   logic [5:0]                hist_ptr;

   task automatic report(string what);
      errors++;
      $display("MISMATCH t=%0t %s", $realtime, what);
   endtask

   task automatic push_prefetch(logic [sfp_pkg::ADDR_W-1:0] a, logic f, ref int n);
      prefetch_type p;
      p = '{a, f, 1'b0};
      if (n < sfp_pkg::MAX_RESULTS) prefetch_q.insert(prefetch_q.size(), p);
      n++;
   endtask

   task automatic push_sequential(logic [sfp_pkg::ADDR_W-1:0] a, ref int n);
      logic [41:0] blk;
      blk = a[47:6];
      for (int i = 1; i <= rbc; i++) push_prefetch({blk + 42'(i), 6'b0}, 1'b0, n);
   endtask

   task automatic close_into_history(logic [sfp_pkg::KEY_W-1:0] k, logic [31:0] fp);
      for (int i = 0; i < 64; i++)
         if (hist_occ[i] && hist_key[i] == k) begin
            hist_fp[i] = fp;
            hist_valid[i] = 1;
            return;
         end
      hist_occ[hist_ptr] = 1;
      hist_valid[hist_ptr] = 1;
      hist_key[hist_ptr] = k;
      hist_fp[hist_ptr] = fp;
      hist_ptr++;
   endtask

   task automatic open_sector(int s, logic [36:0] sec, logic [sfp_pkg::KEY_W-1:0] k);
      act_valid[s] = 1;
      act_tag[s] = sec;
      act_fp[s] = '0;
      act_key[s] = k;
      act_used[s] = 0;
   endtask

   // works out the prefetches of one access; returns how many were issued
   task automatic predict_prefetches(logic [sfp_pkg::ADDR_W-1:0] a,
                                     logic [sfp_pkg::PC_W-1:0] pc, logic hit,
                                     output int cnt,
                                     output logic [sfp_pkg::ADDR_W-1:0] first);
      logic [36:0] sec;
      logic [31:0] bitm;
      logic [sfp_pkg::KEY_W-1:0] k;
      int s, n, q0;
      logic is_open, found;
      sec = a[47:11];
      bitm = 32'd1 << a[10:6];
      s = sec[5:0];
      k = {sec[19:0], pc};
      is_open = act_valid[s] && act_tag[s] == sec;
      n = 0;
      q0 = prefetch_q.size();
      found = 0;
      if (hit) begin
         if (is_open) act_fp[s] |= bitm;
      end else begin
         if (is_open) begin
            if (!act_used[s]) push_sequential(a, n);
            if (act_fp[s] & bitm) begin
               close_into_history(act_key[s], act_fp[s]);
               open_sector(s, sec, k);
            end
         end else begin
            open_sector(s, sec, k);
            for (int i = 0; i < 64 && !found; i++)
               if (hist_occ[i] && hist_valid[i] && hist_key[i] == k) begin
                  found = 1;
                  for (int b = 0; b < 32; b++)
                     if (hist_fp[i][b]) push_prefetch({sec, 5'(b), 6'b0}, 1'b1, n);
                  hist_valid[i] = 0;
                  act_used[s] = 1;
               end
            if (!found) push_sequential(a, n);
         end
         act_fp[s] |= bitm;
         if (n > 0) prefetch_q[prefetch_q.size()-1].last = 1;
      end
      cnt = n > sfp_pkg::MAX_RESULTS ? sfp_pkg::MAX_RESULTS : n;
      first = cnt > 0 ? prefetch_q[q0].addr : '0;
   endtask

   // caller sits at a falling edge; returns at the falling edge after acceptance
   task automatic send(logic [sfp_pkg::ADDR_W-1:0] a, logic [sfp_pkg::PC_W-1:0] pc,
                       logic hit, output int cnt,
                       output logic [sfp_pkg::ADDR_W-1:0] first);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         start = 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_access_address = a;
      req_pc_low = pc;
      req_is_hit = hit;
      start = 1;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      predict_prefetches(a, pc, hit, cnt, first);
      @(negedge clock);
   endtask

   task automatic drain();
      start = 0;
      while (prefetch_q.size() > 0) @(posedge clock);
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic write_rbc(int v);
      drain();
      psel = 1; pwrite = 1; paddr = sfp_pkg::REG_RBC; pwdata = sfp_pkg::CSR_DATA_W'(v);
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
      rbc = sfp_pkg::RBC_W'(v);
      if (prdata !== sfp_pkg::CSR_DATA_W'(rbc) || pready !== 1'b1)
         report($sformatf("register reads %h, want %h", prdata, rbc));
   endtask

   // result checker
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (prefetch_q.size() == 0) report($sformatf("unexpected prefetch %h",
                                                      rsp_prefetch_address));
         else begin
            prefetch_type e;
            e = prefetch_q.pop_front();
            if (rsp_prefetch_address !== e.addr)
               report($sformatf("address %h, want %h", rsp_prefetch_address, e.addr));
            if (rsp_from_footprint !== e.from_fp)
               report($sformatf("from_footprint %b at %h", rsp_from_footprint, e.addr));
            if (rsp_last_of_run !== e.last)
               report($sformatf("last_of_run %b at %h", rsp_last_of_run, e.addr));
         end
      end
   end

   always @(posedge clock)
      if (cycles > LIMIT) begin
         $display("spatial_footprint_prefetcher test failed");
         $finish;
      end

   row_type rows[$] = '{
      '{48'h0,            12'h000, 0, 3,  3, 48'h40},   // cold miss, default run
      '{48'h40,           12'h000, 1, 3,  0, 48'h0},
      '{48'h80,           12'h000, 1, 3,  0, 48'h0},
      '{48'h0,            12'h000, 0, 3,  3, 48'h40},   // repeat miss closes sector
      '{48'hFFFFFFFFFFC0, 12'hFFF, 0, 3,  3, 48'h0},    // wraps past top
      '{48'h123456,       12'h5A5, 1, 3,  0, 48'h0},    // hit, sector not open
      '{48'h20000,        12'h000, 0, 3,  3, 48'h20040},// slot conflict
      '{48'h0,            12'h000, 0, 3,  3, 48'h0},    // footprint replay
      '{48'h40,           12'h000, 0, 3,  0, 48'h0},
      '{48'h40,           12'h000, 0, 3,  0, 48'h0},    // closes, key updated in place
      '{48'h0,            12'h000, 0, 3, -1, 48'h0},
      '{48'hABCDE0000,    12'h123, 0, 0,  0, 48'h0},    // zero-length default
      '{48'hABCDE0040,    12'h123, 0, 0,  0, 48'h0},
      '{48'h555555555000, 12'hAAA, 0, 7,  7, 48'h555555555040},
      '{48'h555555555000, 12'hAAA, 1, 7,  0, 48'h0},
      '{48'h555555555000, 12'hAAA, 0, 7,  7, 48'h555555555040}
   };

   logic [36:0] sec_pool[8];
   logic [sfp_pkg::PC_W-1:0] pc_pool[4];

   initial begin
      int cnt;
      logic [sfp_pkg::ADDR_W-1:0] first;
      logic [36:0] sec;
      logic [sfp_pkg::PC_W-1:0] pc;
      rbc = sfp_pkg::RBC_RESET;
      hist_ptr = '0;
      for (int i = 0; i < 64; i++) begin
         act_valid[i] = 0;
         hist_occ[i] = 0;
         hist_valid[i] = 0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (rows[r]) begin
         if (rows[r].rbc != rbc) write_rbc(rows[r].rbc);
         send(rows[r].addr, rows[r].pc, rows[r].hit, cnt, first);
         if (rows[r].exp_n >= 0 && (cnt != rows[r].exp_n ||
             (cnt > 0 && first !== rows[r].exp_first)))
            report($sformatf("row %0d gives %0d prefetches from %h", r, cnt, first));
      end

      // full footprint: touch every block, close, replay 32 beats
      for (int b = 0; b < 32; b++) send({37'h1F0F0F0F0F, 5'(b), 6'h15}, 12'h777, b != 0,
                                        cnt, first);
      send({37'h1F0F0F0F0F, 11'h0}, 12'h777, 0, cnt, first);
      send({37'h0E0F0F0F0F, 11'h0}, 12'h777, 0, cnt, first);  // evict same slot
      send({37'h1F0F0F0F0F, 11'h0}, 12'h777, 0, cnt, first);

      for (int ph = 0; ph < 4; ph++) begin
         write_rbc(ph == 0 ? 7 : ph == 1 ? 0 : ph == 2 ? $urandom_range(1, 6) : 3);
         gap_pct = ph == 0 ? 13 : ph == 1 ? 67 : 0;
         foreach (sec_pool[i]) sec_pool[i] = 37'({$urandom, $urandom});
         sec_pool[1] = {sec_pool[0][36:6] ^ 31'h1, sec_pool[0][5:0]};  // shares a slot
         foreach (pc_pool[i]) pc_pool[i] = sfp_pkg::PC_W'($urandom);
         for (int k = 0; k < 75; k++) begin
            if ($urandom_range(99) < 10) begin
               send(sfp_pkg::ADDR_W'({$urandom, $urandom}), sfp_pkg::PC_W'($urandom),
                    1'($urandom_range(1)), cnt, first);
            end else begin
               sec = sec_pool[$urandom_range(7)];
               pc = pc_pool[$urandom_range(3)];
               send({sec, 5'($urandom), 6'($urandom)}, pc, $urandom_range(99) < 55,
                    cnt, first);
            end
         end
      end

      drain();
      repeat (100) @(posedge clock);
      while (prefetch_q.size() > 0) begin
         prefetch_type e;
         e = prefetch_q.pop_front();
         report($sformatf("prefetch %h never issued", e.addr));
      end
      if (errors == 0)
         $display("spatial_footprint_prefetcher test passed");
      else
         $display("spatial_footprint_prefetcher test failed");
      $finish;
   end

endmodule
